// ===== hdl/gda_pkg.sv =====
// gda_pkg: shared types, calendar constants and lookup functions for the
// gregorian date arithmetic block; no dependencies
package gda_pkg;

    // number of pipeline registers from input register to result register
    localparam int NSTG = 12;

    localparam logic [17:0] DAYS_PER_400Y   = 18'd146097;
    localparam logic [15:0] DAYS_PER_100Y   = 16'd36524;
    localparam logic [10:0] DAYS_PER_4Y     = 11'd1461;
    localparam logic [8:0]  DAYS_PER_Y      = 9'd365;
    localparam logic [21:0] LAST_DAY_NUMBER = 22'd3652058;
    localparam logic [13:0] MAX_YEAR        = 14'd9999;
    localparam logic [6:0]  DAYS_CENT_DIV   = 7'd100;

    // reciprocal multipliers: m = ceil(2^k / d), k = input bits + ceil(log2 d)
    localparam int K_Y100 = 21;
    localparam logic [14:0] M_Y100 =
        15'(((64'd1 << K_Y100) + 64'(DAYS_CENT_DIV) - 64'd1) / 64'(DAYS_CENT_DIV));
    localparam int K_400Y = 40;
    localparam logic [22:0] M_400Y =
        23'(((64'd1 << K_400Y) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y));
    localparam int K_100Y = 34;
    localparam logic [18:0] M_100Y =
        19'(((64'd1 << K_100Y) + 64'(DAYS_PER_100Y) - 64'd1) / 64'(DAYS_PER_100Y));
    localparam int K_4Y = 27;
    localparam logic [16:0] M_4Y =
        17'(((64'd1 << K_4Y) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic        func;
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [13:0] end_year;
        logic [3:0]  end_month;
        logic [4:0]  end_day;
        logic [21:0] offset_days;
    } t_in_word;

    typedef struct packed {
        logic signed [22:0] day_difference;
        logic [13:0]        result_year;
        logic [3:0]         result_month;
        logic [4:0]         result_day;
        logic               range_error;
    } t_out_word;

    // days before the first of the month in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // month length in a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] v;
        unique case (m)
            4'd2:                      v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
            default:                   v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/gregorian_date_arithmetic_top.sv =====
// gregorian_date_arithmetic_top: proleptic gregorian day count and date shift
// pipeline; depends on gda_pkg
//
// throughput: one word per cycle while the output is not stalled, through the twelve-register pipeline
// (input register, ten working stages, result register) with per-stage bubble fill
// reset: synchronous active low, clears the stage valid bits only
module gregorian_date_arithmetic_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gda_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gda_pkg::t_out_word o_out_word
);
    import gda_pkg::*;

    // per-date terms after the reciprocal multiply
    typedef struct packed {
        logic [13:0] p;      // year minus one
        logic [22:0] p365;   // days of whole years
        logic [7:0]  q;      // (year - 1) / 100
        logic        yok;    // year in range
        logic [3:0]  m;
        logic [4:0]  d;
    } t_d1;

    // per-date partial day number and check
    typedef struct packed {
        logic [22:0] base;   // days before jan 1st of the year
        logic [8:0]  moff;   // day of year, zero based
        logic        ok;
    } t_d2;

    // what every word carries down the conversion stages
    typedef struct packed {
        logic               func;
        logic               err;
        logic signed [22:0] diff;
    } t_side;

    // ---------------------------------------------------------------
    // stage control: a stage loads when it is empty or its successor moves
    // ---------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_adv;

    always_comb begin
        w_adv[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // date to day number helpers
    // ---------------------------------------------------------------
    // year terms: 365 * (y - 1) and (y - 1) / 100 by reciprocal multiply
    function automatic t_d1 f_year_terms(input logic [13:0] y, input logic [3:0] m,
                                         input logic [4:0] d);
        t_d1         v;
        logic [28:0] prod;
        v.p    = y - 14'd1;
        v.p365 = 23'(v.p) * 23'(DAYS_PER_Y);
        prod   = 29'(v.p) * 29'(M_Y100);
        v.q    = prod[K_Y100+7:K_Y100];
        v.yok  = (y != 14'd0) && (y <= MAX_YEAR);
        v.m    = m;
        v.d    = d;
        return v;
    endfunction

    // leap test from (y - 1) and its century quotient, validity, day of year
    function automatic t_d2 f_date_terms(input t_d1 a);
        t_d2         v;
        logic [13:0] rem;
        logic        leap;
        logic [4:0]  len;
        rem    = a.p - 14'(a.q) * 14'(DAYS_CENT_DIV);
        // y divisible by 4, and not a century year unless y / 100 is divisible by 4
        leap   = (a.p[1:0] == 2'd3) && ((rem != 14'(DAYS_CENT_DIV - 7'd1)) ||
                 (a.q[1:0] == 2'd3));
        len    = month_len(a.m) + 5'(a.m == MONTH_FEB && leap);
        v.ok   = a.yok && (a.m >= MONTH_JAN) && (a.m <= MONTH_DEC) &&
                 (a.d != 5'd0) && (a.d <= len);
        v.moff = month_start(a.m) + 9'(a.m > MONTH_FEB && leap) + 9'(a.d) - 9'd1;
        v.base = a.p365 + 23'(a.p[13:2]) - 23'(a.q) + 23'(a.q[7:2]);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // stage registers
    // ---------------------------------------------------------------
    t_in_word    r_in;                       // input register
    t_d1         r1_s, r1_e;                 // year terms
    logic        r1_func;
    logic [21:0] r1_off;
    t_d2         r2_s, r2_e;                 // partial day numbers
    logic        r2_func;
    logic [21:0] r2_off;
    logic [21:0] r3_dn_s, r3_dn_e;           // day numbers
    logic        r3_func, r3_err;
    logic [21:0] r3_off;
    t_side       r_side [4:NSTG-2];          // side info, stages 4 to 10
    logic [21:0] r4_n;                       // day number of the shifted date
    logic [4:0]  r5_q400;
    logic [21:0] r5_n;
    logic [4:0]  r6_q400, r7_q400, r8_q400, r9_q400;
    logic [17:0] r6_r, r7_r;                 // days into the 400 year cycle
    logic [1:0]  r7_q100, r8_q100, r9_q100;
    logic [15:0] r8_r2, r9_r2;               // days into the century
    logic [4:0]  r9_q4;
    logic [13:0] r10_yr;
    logic [8:0]  r10_doy;
    logic        r10_leap;
    t_out_word   r_out;                      // result register

    // combinational next values
    t_d1                n1_s, n1_e;
    t_d2                n2_s, n2_e;
    logic [21:0]        n3_dn_s, n3_dn_e;
    logic               n3_err;
    logic signed [22:0] n4_diff;
    logic [22:0]        n4_sum;
    logic               n4_err;
    logic [44:0]        n5_prod;
    logic [17:0]        n6_r;
    logic [36:0]        n7_prod;
    logic [2:0]         n7_qraw;
    logic [1:0]         n7_q100;
    logic [15:0]        n8_r2;
    logic [32:0]        n9_prod;
    logic [10:0]        n10_r3;
    logic [1:0]         n10_q1;
    logic [8:0]         n10_doy;
    logic [13:0]        n10_yr;
    logic               n10_leap;
    logic [3:0]         n11_mon;
    logic [8:0]         n11_mst;
    logic [8:0]         w11_st;
    t_out_word          n_out;

    always_comb begin
        // stages 1 to 3: both dates to day numbers
        n1_s    = f_year_terms(r_in.start_year, r_in.start_month, r_in.start_day);
        n1_e    = f_year_terms(r_in.end_year, r_in.end_month, r_in.end_day);
        n2_s    = f_date_terms(r1_s);
        n2_e    = f_date_terms(r1_e);
        n3_dn_s = 22'(r2_s.base + 23'(r2_s.moff));
        n3_dn_e = 22'(r2_e.base + 23'(r2_e.moff));
        // the end date only matters for the day count
        n3_err  = !r2_s.ok || (!r2_func && !r2_e.ok);

        // stage 4: difference, or start plus offset with the upper bound check
        n4_diff = $signed({1'b0, r3_dn_e}) - $signed({1'b0, r3_dn_s});
        n4_sum  = {1'b0, r3_dn_s} + {1'b0, r3_off};
        n4_err  = r3_err || (r3_func && (n4_sum > 23'(LAST_DAY_NUMBER)));

        // stages 5 to 10: day number back to year and day of year
        n5_prod = 45'(r4_n) * 45'(M_400Y);
        n6_r    = 18'(r5_n - 22'(r5_q400) * 22'(DAYS_PER_400Y));
        n7_prod = 37'(r6_r) * 37'(M_100Y);
        n7_qraw = n7_prod[K_100Y+2:K_100Y];
        // last day of a 400 year cycle belongs to the fourth century
        n7_q100 = (n7_qraw > 3'd3) ? 2'd3 : n7_qraw[1:0];
        n8_r2   = 16'(r7_r - 18'(r7_q100) * 18'(DAYS_PER_100Y));
        n9_prod = 33'(r8_r2) * 33'(M_4Y);
        n10_r3  = 11'(r9_r2 - 16'(r9_q4) * 16'(DAYS_PER_4Y));
        // last day of a four year run belongs to its fourth year
        priority if (n10_r3 >= 11'(3 * DAYS_PER_Y)) begin
            n10_q1 = 2'd3;
        end else if (n10_r3 >= 11'(2 * DAYS_PER_Y)) begin
            n10_q1 = 2'd2;
        end else if (n10_r3 >= 11'(DAYS_PER_Y)) begin
            n10_q1 = 2'd1;
        end else begin
            n10_q1 = 2'd0;
        end
        n10_doy  = 9'(n10_r3 - 11'(n10_q1) * 11'(DAYS_PER_Y));
        n10_yr   = 14'(r9_q400) * 14'd400 + 14'(r9_q100) * 14'(DAYS_CENT_DIV) +
                   14'(r9_q4) * 14'd4 + 14'(n10_q1) + 14'd1;
        // fourth year of a run is leap unless it closes a century not divisible by 400
        n10_leap = (n10_q1 == 2'd3) && ((r9_q4 != 5'd24) || (r9_q100 == 2'd3));

        // stage 11: month by comparing against every month start
        n11_mon = MONTH_JAN;
        n11_mst = 9'd0;
        for (int k = 2; k <= 12; k++) begin
            w11_st = month_start(4'(k)) + 9'(4'(k) > MONTH_FEB && r10_leap);
            if (w11_st <= r10_doy) begin
                n11_mon = 4'(k);
                n11_mst = w11_st;
            end
        end
        w11_st = 9'd0;

        n_out = '0;
        if (r_side[NSTG-2].err) begin
            n_out.range_error = 1'b1;
        end else if (!r_side[NSTG-2].func) begin
            n_out.day_difference = r_side[NSTG-2].diff;
        end else begin
            n_out.result_year  = r10_yr;
            n_out.result_month = n11_mon;
            n_out.result_day   = 5'(r10_doy - n11_mst + 9'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_in <= i_in_word;
        end
        if (w_adv[1]) begin
            r1_s    <= n1_s;
            r1_e    <= n1_e;
            r1_func <= r_in.func;
            r1_off  <= r_in.offset_days;
        end
        if (w_adv[2]) begin
            r2_s    <= n2_s;
            r2_e    <= n2_e;
            r2_func <= r1_func;
            r2_off  <= r1_off;
        end
        if (w_adv[3]) begin
            r3_dn_s <= n3_dn_s;
            r3_dn_e <= n3_dn_e;
            r3_func <= r2_func;
            r3_err  <= n3_err;
            r3_off  <= r2_off;
        end
        if (w_adv[4]) begin
            r_side[4].func <= r3_func;
            r_side[4].err  <= n4_err;
            r_side[4].diff <= n4_diff;
            r4_n           <= n4_sum[21:0];
        end
        for (int k = 5; k <= NSTG - 2; k++) begin
            if (w_adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_adv[5]) begin
            r5_q400 <= n5_prod[K_400Y+4:K_400Y];
            r5_n    <= r4_n;
        end
        if (w_adv[6]) begin
            r6_r    <= n6_r;
            r6_q400 <= r5_q400;
        end
        if (w_adv[7]) begin
            r7_q100 <= n7_q100;
            r7_r    <= r6_r;
            r7_q400 <= r6_q400;
        end
        if (w_adv[8]) begin
            r8_r2   <= n8_r2;
            r8_q100 <= r7_q100;
            r8_q400 <= r7_q400;
        end
        if (w_adv[9]) begin
            r9_q4   <= 5'(n9_prod[32:K_4Y]);
            r9_r2   <= r8_r2;
            r9_q100 <= r8_q100;
            r9_q400 <= r8_q400;
        end
        if (w_adv[10]) begin
            r10_yr   <= n10_yr;
            r10_doy  <= n10_doy;
            r10_leap <= n10_leap;
        end
        if (w_adv[11]) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== hdl/gda_checker.sv =====
// gda_checker: port-level checks on the date arithmetic block, bound to its top
// level; depends on gda_pkg and gregorian_date_arithmetic_top
module gda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gda_pkg::t_out_word o_out_word
);
    import gda_pkg::*;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // an empty result register means the whole pipe can take a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // error words carry nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.range_error |->
            o_out_word.day_difference == 23'sd0 && o_out_word.result_year == 14'd0 &&
            o_out_word.result_month == 4'd0 && o_out_word.result_day == 5'd0)
        else $error("error word with payload");

    // a day count and a shifted date never share a word
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.day_difference != 23'sd0 |->
            o_out_word.result_year == 14'd0 && o_out_word.result_month == 4'd0 &&
            o_out_word.result_day == 5'd0)
        else $error("day count and date mixed");

    // shifted date fields in calendar range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_year != 14'd0 |->
            o_out_word.result_year <= MAX_YEAR && o_out_word.result_month >= MONTH_JAN &&
            o_out_word.result_month <= MONTH_DEC && o_out_word.result_day != 5'd0)
        else $error("shifted date out of range");

endmodule

bind gregorian_date_arithmetic_top gda_checker u_gda_checker (.*);

// ===== verif/gregorian_date_arithmetic_top_test.sv =====
// gregorian_date_arithmetic_top_test: self-checking bench for the gregorian date block,
// a directed table then random words, each result compared with a behavioural predictor
// depends on gda_pkg and gregorian_date_arithmetic_top
`timescale 1ns / 1ps

module gregorian_date_arithmetic_top_test;
    import gda_pkg::*;

    // operation select codes
    localparam logic OP_SPAN  = 1'b0;
    localparam logic OP_SHIFT = 1'b1;

    localparam int unsigned MONTH_LENGTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DAYS_BEFORE_MONTH [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    // years that sit on the leap rule boundaries or the range ends
    localparam int unsigned EDGE_YEARS [12] =
        '{1, 2, 4, 99, 100, 400, 1600, 1900, 2000, 2100, 9998, 9999};
    localparam int unsigned LAST_DAY = 3652058;
    localparam int RANDOM_WORDS = 1200;

    localparam t_out_word ERR_RES = t_out_word'{23'sd0, 14'd0, 4'd0, 5'd0, 1'b1};

    // one directed row: the word, and a typed-in result where it is obvious
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_case;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;

    t_out_word  pending_results [$];
    t_case      date_cases [$];

    int         words_sent;
    int         span_words;
    int         shift_words;
    int         flagged_words;
    int         results_checked;
    int         mismatches;
    bit         in_idle;
    bit         out_idle;

    gregorian_date_arithmetic_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------

    // 4/100/400 rule
    function automatic bit leap_yr(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        int unsigned n;
        n = MONTH_LENGTH[(m - 1) % 12];
        if (m == 2 && leap_yr(y)) begin
            n++;
        end
        return n;
    endfunction

    function automatic bit date_valid(input int unsigned y, m, d);
        if (y < 1 || y > 9999) begin
            return 1'b0;
        end
        if (m < 1 || m > 12) begin
            return 1'b0;
        end
        return (d >= 1) && (d <= month_days(y, m));
    endfunction

    // days since 0001-01-01, valid dates only; leap day counts from march on
    function automatic int unsigned day_count(input int unsigned y, m, d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + DAYS_BEFORE_MONTH[(m - 1) % 12];
        if (m > 2 && leap_yr(y)) begin
            n++;
        end
        return n + d - 1;
    endfunction

    // inverse of day_count: peel off 400, 100, 4 and 1 year blocks, then months
    function automatic void split_day_count(input int unsigned n, output int unsigned y,
                                            output int unsigned m, output int unsigned d);
        int unsigned q400, q100, q4, q1, r, len;
        q400 = n / 32'(DAYS_PER_400Y);
        r    = n % 32'(DAYS_PER_400Y);
        q100 = r / 32'(DAYS_PER_100Y);
        if (q100 > 3) begin
            q100 = 3;
        end
        r   -= q100 * 32'(DAYS_PER_100Y);
        q4   = r / 32'(DAYS_PER_4Y);
        r   -= q4 * 32'(DAYS_PER_4Y);
        q1   = r / 32'(DAYS_PER_Y);
        // last day of a leap year in the block
        if (q1 > 3) begin
            q1 = 3;
        end
        r   -= q1 * 32'(DAYS_PER_Y);
        y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
        m    = 1;
        len  = month_days(y, m);
        while (r >= len && m != 12) begin
            r  -= len;
            m++;
            len = month_days(y, m);
        end
        d = r + 1;
    endfunction

    function automatic t_out_word date_arith_result(input t_in_word w);
        t_out_word   r;
        int unsigned n, y, m, d;
        int          diff;
        r = '0;
        if (!date_valid(w.start_year, w.start_month, w.start_day)) begin
            r.range_error = 1'b1;
            return r;
        end
        if (w.func == OP_SPAN) begin
            if (!date_valid(w.end_year, w.end_month, w.end_day)) begin
                r.range_error = 1'b1;
                return r;
            end
            diff = int'(day_count(w.end_year, w.end_month, w.end_day))
                 - int'(day_count(w.start_year, w.start_month, w.start_day));
            r.day_difference = 23'(diff);
            return r;
        end
        n = day_count(w.start_year, w.start_month, w.start_day) + w.offset_days;
        if (n > LAST_DAY) begin
            r.range_error = 1'b1;
            return r;
        end
        split_day_count(n, y, m, d);
        r.result_year  = 14'(y);
        r.result_month = 4'(m);
        r.result_day   = 5'(d);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------

    // shift rows carry all-ones end fields, span rows an all-ones offset: both unused
    function automatic t_case span_row(input int unsigned sy, sm, sd, ey, em, ed,
                                       input bit typed = 1'b0, input t_out_word want = '0);
        t_case c;
        c.word             = '0;
        c.word.func        = OP_SPAN;
        c.word.start_year  = 14'(sy);
        c.word.start_month = 4'(sm);
        c.word.start_day   = 5'(sd);
        c.word.end_year    = 14'(ey);
        c.word.end_month   = 4'(em);
        c.word.end_day     = 5'(ed);
        c.word.offset_days = '1;
        c.typed            = typed;
        c.want             = want;
        return c;
    endfunction

    function automatic t_case shift_row(input int unsigned sy, sm, sd, off,
                                        input bit typed = 1'b0, input t_out_word want = '0);
        t_case c;
        c.word             = '0;
        c.word.func        = OP_SHIFT;
        c.word.start_year  = 14'(sy);
        c.word.start_month = 4'(sm);
        c.word.start_day   = 5'(sd);
        c.word.end_year    = '1;
        c.word.end_month   = '1;
        c.word.end_day     = '1;
        c.word.offset_days = 22'(off);
        c.typed            = typed;
        c.want             = want;
        return c;
    endfunction

    function automatic t_out_word span_res(input int diff);
        t_out_word r;
        r = '0;
        r.day_difference = 23'(diff);
        return r;
    endfunction

    function automatic t_out_word date_res(input int unsigned y, m, d);
        t_out_word r;
        r = '0;
        r.result_year  = 14'(y);
        r.result_month = 4'(m);
        r.result_day   = 5'(d);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random words
    // ------------------------------------------------------------------

    // valid date, leaning on february, month ends and leap rule years
    function automatic void rand_valid_date(output int unsigned y, m, d);
        int unsigned len;
        if ($urandom_range(0, 7) == 0) begin
            y = EDGE_YEARS[$urandom_range(0, 11)];
        end else begin
            y = $urandom_range(1, 9999);
        end
        m = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(1, 12);
        len = month_days(y, m);
        case ($urandom_range(0, 5))
            0: begin
                d = 1;
            end
            1: begin
                d = len;
            end
            2: begin
                d = len - 1;
            end
            default: begin
                d = $urandom_range(1, len);
            end
        endcase
    endfunction

    // mostly well-formed words with random content, some broken, some pure noise
    function automatic t_in_word rand_date_word();
        t_in_word    w;
        int unsigned y, m, d, room;
        int unsigned kind;
        w.func        = 1'($urandom);
        w.start_year  = 14'($urandom);
        w.start_month = 4'($urandom);
        w.start_day   = 5'($urandom);
        w.end_year    = 14'($urandom);
        w.end_month   = 4'($urandom);
        w.end_day     = 5'($urandom);
        w.offset_days = 22'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            return w;
        end
        rand_valid_date(y, m, d);
        w.start_year  = 14'(y);
        w.start_month = 4'(m);
        w.start_day   = 5'(d);
        room = LAST_DAY - day_count(y, m, d);
        rand_valid_date(y, m, d);
        w.end_year    = 14'(y);
        w.end_month   = 4'(m);
        w.end_day     = 5'(d);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                w.offset_days = 22'($urandom_range(0, 400));
            end
            3, 4: begin
                w.offset_days = 22'($urandom_range(0, 40000));
            end
            5, 6, 7: begin
                w.offset_days = 22'($urandom_range(0, room));
            end
            // just past the last representable day
            8: begin
                w.offset_days = 22'(room + $urandom_range(1, 1000));
            end
            default: begin
            end
        endcase
        if (kind < 20) begin
            // break one date field
            case ($urandom_range(0, 4))
                0: begin
                    len_fix: begin
                        int unsigned len;
                        len = month_days(w.start_year, w.start_month);
                        w.start_day = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
                    end
                end
                1: begin
                    w.start_month = ($urandom_range(0, 1) == 0) ? 4'd0
                                                                : 4'($urandom_range(13, 15));
                end
                2: begin
                    w.start_year = ($urandom_range(0, 1) == 0) ? 14'd0
                                                               : 14'($urandom_range(10000, 16383));
                end
                3: begin
                    w.end_day = 5'd0;
                end
                default: begin
                    w.end_year = 14'($urandom_range(10000, 16383));
                end
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------

    // offer one word, after a random gap while in_idle is set, and hold it until the block takes it
    task automatic push_date_word(input t_in_word w, input t_out_word want);
        int gap;
        gap = in_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(want);
        words_sent++;
        if (w.func == OP_SPAN) begin
            span_words++;
        end else begin
            shift_words++;
        end
        if (want.range_error) begin
            flagged_words++;
        end
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        bit        bad;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result word: diff %0d date %0d-%0d-%0d err %0b",
                         got.day_difference, got.result_year, got.result_month,
                         got.result_day, got.range_error);
            end
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        bad = (got.day_difference !== want.day_difference)
           || (got.result_year    !== want.result_year)
           || (got.result_month   !== want.result_month)
           || (got.result_day     !== want.result_day)
           || (got.range_error    !== want.range_error);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on result %0d: expected diff %0d date %0d-%0d-%0d err %0b",
                         results_checked, want.day_difference, want.result_year,
                         want.result_month, want.result_day, want.range_error);
                $display("    got diff %0d date %0d-%0d-%0d err %0b",
                         got.day_difference, got.result_year, got.result_month,
                         got.result_day, got.range_error);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // clock, run limit
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // far beyond the slowest clean run
    initial begin
        #2_000_000;
        $display("gregorian_date_arithmetic_top_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, each accepted word checked in order
    // ------------------------------------------------------------------

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = out_idle ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_result(o_out_word);
        end
    end

    // ------------------------------------------------------------------
    // stimulus: reset, directed table, random words, drain
    // ------------------------------------------------------------------

    initial begin
        t_in_word  w;
        t_out_word want;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        in_idle     = 1'b1;
        out_idle    = 1'b1;

        // range ends both ways, and a zero span
        date_cases.push_back(span_row(1, 1, 1, 9999, 12, 31, 1'b1, span_res(3652058)));
        date_cases.push_back(span_row(9999, 12, 31, 1, 1, 1, 1'b1, span_res(-3652058)));
        date_cases.push_back(span_row(2024, 6, 15, 2024, 6, 15, 1'b1, span_res(0)));
        // shifts onto and past the last day
        date_cases.push_back(shift_row(1, 1, 1, 3652058, 1'b1, date_res(9999, 12, 31)));
        date_cases.push_back(shift_row(1, 1, 1, 3652059, 1'b1, ERR_RES));
        date_cases.push_back(shift_row(9999, 12, 31, 0, 1'b1, date_res(9999, 12, 31)));
        date_cases.push_back(shift_row(9999, 12, 31, 1, 1'b1, ERR_RES));
        date_cases.push_back(shift_row(1, 1, 1, 4194303, 1'b1, ERR_RES));
        // leap day only in leap years, month and year rollover
        date_cases.push_back(shift_row(2000, 2, 28, 1, 1'b1, date_res(2000, 2, 29)));
        date_cases.push_back(shift_row(1900, 2, 28, 1, 1'b1, date_res(1900, 3, 1)));
        date_cases.push_back(shift_row(2000, 12, 31, 1, 1'b1, date_res(2001, 1, 1)));
        date_cases.push_back(span_row(2000, 2, 1, 2000, 3, 1, 1'b1, span_res(29)));
        date_cases.push_back(span_row(1900, 2, 1, 1900, 3, 1, 1'b1, span_res(28)));
        date_cases.push_back(span_row(2000, 1, 31, 2000, 2, 29));
        date_cases.push_back(shift_row(2000, 2, 29, 365));
        date_cases.push_back(shift_row(1600, 2, 29, 146097));
        // invalid start dates
        date_cases.push_back(span_row(2023, 0, 10, 2023, 1, 1, 1'b1, ERR_RES));
        date_cases.push_back(shift_row(2023, 13, 10, 5, 1'b1, ERR_RES));
        date_cases.push_back(shift_row(2023, 5, 0, 5, 1'b1, ERR_RES));
        date_cases.push_back(span_row(2023, 4, 31, 2023, 5, 1, 1'b1, ERR_RES));
        date_cases.push_back(span_row(1900, 2, 29, 1900, 3, 1, 1'b1, ERR_RES));
        date_cases.push_back(shift_row(0, 6, 1, 10, 1'b1, ERR_RES));
        date_cases.push_back(span_row(16383, 15, 31, 1, 1, 1, 1'b1, ERR_RES));
        // invalid end dates, only seen by the span operation
        date_cases.push_back(span_row(2023, 7, 4, 2023, 0, 1, 1'b1, ERR_RES));
        date_cases.push_back(span_row(2023, 7, 4, 2023, 2, 29, 1'b1, ERR_RES));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (date_cases[k]) begin
            want = date_cases[k].typed ? date_cases[k].want
                                       : date_arith_result(date_cases[k].word);
            push_date_word(date_cases[k].word, want);
        end

        // random part, pacing redrawn every 150 words so some stretches run flat out
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 150 == 0) begin
                in_idle  = ($urandom_range(0, 2) != 0);
                out_idle = ($urandom_range(0, 2) != 0);
            end
            w = rand_date_word();
            push_date_word(w, date_arith_result(w));
        end
        i_in_valid <= 1'b0;
        in_idle     = 1'b1;
        out_idle    = 1'b1;

        // drain, then watch a little longer for stray result words
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NSTG + 8) @(posedge i_clk);

        $display("%0d words sent: %0d day spans, %0d date shifts, %0d with the range flag",
                 words_sent, span_words, shift_words, flagged_words);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("gregorian_date_arithmetic_top_test: done, clean");
        end else begin
            $display("gregorian_date_arithmetic_top_test: done, errors");
        end
        $finish;
    end

endmodule
